@@ hw/rtl/ddo_pkg.sv @@
// shared constants, codes and arithmetic helpers for the odometry / go-to-goal block
package ddo_pkg;

    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int MUL_W   = 36;
    localparam int PROD_W  = 72;
    localparam int DIV_NW  = 64;
    localparam int DIV_DW  = 24;
    localparam int COR_W   = 36;
    localparam int COR_ZW  = 34;
    localparam int ATAN_IW = 5;
    localparam int CFG_W   = 32;
    localparam int CFG_IW  = 3;
    localparam int SUM_W   = 56;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [COR_ZW-1:0] PI_Q30   = 34'sd3373259426;
    localparam logic signed [MUL_W-1:0]  KINV_Q24 = 36'sd10188014;
    localparam logic signed [COR_W-1:0]  KINV_Q30 = 36'sd652032874;
    localparam logic signed [SUM_W-1:0]  DRIVE_LIM = 56'sd68451041280;
    localparam logic signed [PROD_W-1:0] TRAVEL_RND = 72'sd2048;
    localparam logic signed [COR_ZW-1:0] BEAR_RND   = 34'sd65536;

    localparam logic [23:0] DPP_RST    = 24'd283936;
    localparam logic [22:0] WB_RST     = 23'd125829;
    localparam logic [15:0] GL_RST     = 16'd218;
    localparam logic [15:0] GA_RST     = 16'd51;
    localparam logic [30:0] RADIUS_RST = 31'd52428800;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IW-1:0] {
        CFG_DIST   = 3'd0,
        CFG_WBASE  = 3'd1,
        CFG_TX     = 3'd2,
        CFG_TY     = 3'd3,
        CFG_GLIN   = 3'd4,
        CFG_GANG   = 3'd5,
        CFG_RADIUS = 3'd6
    } t_cfg_idx;

    // atan(2^-i) in Q2.30
    function automatic logic signed [COR_ZW-1:0] atan_q30(input logic [ATAN_IW-1:0] i);
        logic signed [COR_ZW-1:0] r;
        case (i)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
        logic signed [17:0] r;
        if (a > PI_Q13) begin
            r = a - TWO_PI_Q13;
        end else if (a < -PI_Q13) begin
            r = a + TWO_PI_Q13;
        end else begin
            r = a;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat_heading(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'(PI_Q13)) begin
            r = 16'(PI_Q13);
        end else if (v < -64'(PI_Q13)) begin
            r = -16'(PI_Q13);
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // count * dist_per_pulse rounded half up to Q12.20
    function automatic logic signed [31:0] travel(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + TRAVEL_RND;
        t = t >>> 12;
        return sat32(t[63:0]);
    endfunction

    // saturate to +/-255 in Q28, then truncate toward zero
    function automatic logic signed [8:0] drive(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] m;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] t;
        logic signed [8:0] r;
        if (s > DRIVE_LIM) begin
            m = DRIVE_LIM;
        end else if (s < -DRIVE_LIM) begin
            m = -DRIVE_LIM;
        end else begin
            m = s;
        end
        mag = m[SUM_W-1] ? SUM_W'(-m) : SUM_W'(m);
        t = mag >> 28;
        r = $signed({1'b0, t[7:0]});
        return m[SUM_W-1] ? -r : r;
    endfunction

endpackage

@@ hw/rtl/ddo_if.sv @@
// valid/ready channel interfaces for encoder/tick items and pose/drive results
interface ddo_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       enc_a;
    logic       enc_b;
    modport source(output valid, command, enc_a, enc_b, input ready);
    modport sink(input valid, command, enc_a, enc_b, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [8:0]  left_drive;
    logic signed [8:0]  right_drive;
    logic               arrived;
    modport source(output valid, pos_x, pos_y, heading, left_drive, right_drive, arrived,
                   input ready);
    modport sink(input valid, pos_x, pos_y, heading, left_drive, right_drive, arrived,
                 output ready);
endinterface

@@ hw/rtl/ddo_mul.sv @@
// bit-serial signed multiplier, one multiplier bit per cycle
module ddo_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ddo_pkg::MUL_W-1:0]     i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]     i_b,
    output logic                                 o_done,
    output logic signed [ddo_pkg::PROD_W-1:0]    o_p
);
    localparam int CW = $clog2(ddo_pkg::MUL_W);

    logic                                r_busy;
    logic                                r_done;
    logic [CW-1:0]                       r_cnt;
    logic signed [ddo_pkg::PROD_W-1:0]   r_acc;
    logic signed [ddo_pkg::PROD_W-1:0]   r_a;
    logic signed [ddo_pkg::MUL_W-1:0]    r_b;
    logic                                last;
    logic signed [ddo_pkg::PROD_W-1:0]   addend;

    assign last = (r_cnt == CW'(ddo_pkg::MUL_W - 1));

    // top bit of the multiplier carries negative weight
    always_comb begin
        if (!r_b[0]) begin
            addend = '0;
        end else if (last) begin
            addend = -r_a;
        end else begin
            addend = r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= ddo_pkg::PROD_W'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= r_acc + addend;
            r_a   <= r_a <<< 1;
            r_b   <= r_b >>> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

@@ hw/rtl/ddo_div.sv @@
// restoring signed divider, truncates toward zero, one quotient bit per cycle
module ddo_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ddo_pkg::DIV_NW-1:0]    i_n,
    input  logic signed [ddo_pkg::DIV_DW-1:0]    i_d,
    output logic                                 o_done,
    output logic signed [ddo_pkg::DIV_NW-1:0]    o_q
);
    localparam int NW = ddo_pkg::DIV_NW;
    localparam int DW = ddo_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic            r_neg;
    logic [NW-1:0]   r_n;
    logic [DW-1:0]   r_d;
    logic [DW-1:0]   r_rem;
    logic [DW:0]     rem_sh;
    logic            fits;
    logic            last;

    assign last   = (r_cnt == CW'(NW - 1));
    assign rem_sh = {r_rem, r_n[NW-1]};
    assign fits   = (rem_sh >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_n[NW-1] ^ i_d[DW-1];
            r_n   <= i_n[NW-1] ? NW'(-i_n) : NW'(i_n);
            r_d   <= i_d[DW-1] ? DW'(-i_d) : DW'(i_d);
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(rem_sh - {1'b0, r_d}) : rem_sh[DW-1:0];
            r_n   <= {r_n[NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? -$signed(r_n) : $signed(r_n);
endmodule

@@ hw/rtl/ddo_cordic.sv @@
// iterative cordic, rotation mode (sin/cos) or vectoring mode (magnitude/angle)
module ddo_cordic #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_vec,
    input  logic signed [ddo_pkg::COR_W-1:0]     i_x0,
    input  logic signed [ddo_pkg::COR_W-1:0]     i_y0,
    input  logic signed [ddo_pkg::COR_ZW-1:0]    i_z0,
    output logic                                 o_done,
    output logic signed [ddo_pkg::COR_W-1:0]     o_x,
    output logic signed [ddo_pkg::COR_W-1:0]     o_y,
    output logic signed [ddo_pkg::COR_ZW-1:0]    o_z
);
    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                              r_busy;
    logic                              r_done;
    logic [IW-1:0]                     r_i;
    logic signed [ddo_pkg::COR_W-1:0]  r_x;
    logic signed [ddo_pkg::COR_W-1:0]  r_y;
    logic signed [ddo_pkg::COR_ZW-1:0] r_z;
    logic signed [ddo_pkg::COR_W-1:0]  sx;
    logic signed [ddo_pkg::COR_W-1:0]  sy;
    logic signed [ddo_pkg::COR_ZW-1:0] ang;
    logic                              dir;
    logic                              last;

    assign sx   = r_x >>> r_i;
    assign sy   = r_y >>> r_i;
    assign ang  = ddo_pkg::atan_q30(ddo_pkg::ATAN_IW'(r_i));
    // rotation drives z to zero, vectoring drives y to zero
    assign dir  = i_vec ? r_y[ddo_pkg::COR_W-1] : !r_z[ddo_pkg::COR_ZW-1];
    assign last = (r_i == IW'(STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x0;
            r_y <= i_y0;
            r_z <= i_z0;
        end else if (r_busy) begin
            if (dir) begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + ang;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule

@@ hw/rtl/diff_drive_odometry_go_to_goal_unit.sv @@
// encoder counting, dead reckoning and go-to-goal drive law around shared mul/div/cordic units
// encoder edge transactions: accepted only in idle and applied to the wheel count, no result
// tick transactions: a straight move or an arc, sequenced through the shared units:
//   the serial multiplier (up to 8 uses), the serial divider (up to 3 uses) and the cordic
// one tick in flight; input ready again once its result transaction is taken
// synchronous active-low reset: counts, pose and sequencer cleared, registers to defaults
module diff_drive_odometry_go_to_goal_unit #(
    parameter int COUNT_WIDTH  = ddo_pkg::COUNT_WIDTH_DEF,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ddo_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [ddo_pkg::CFG_W-1:0]     i_cfg_data,
    ddo_in_if.sink                        i_item,
    ddo_out_if.source                     o_result
);
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam int MW = ddo_pkg::MUL_W;
    localparam int CW = ddo_pkg::COR_W;
    localparam int ZW = ddo_pkg::COR_ZW;

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_TRAV_L = 20'h00002,
        S_TRAV_R = 20'h00004,
        S_DIV_DH = 20'h00008,
        S_SC0    = 20'h00010,
        S_MUL_X  = 20'h00020,
        S_MUL_Y  = 20'h00040,
        S_SC1    = 20'h00080,
        S_MUL_AX = 20'h00100,
        S_DIV_AX = 20'h00200,
        S_MUL_AY = 20'h00400,
        S_DIV_AY = 20'h00800,
        S_VEC    = 20'h01000,
        S_MAG    = 20'h02000,
        S_CHK    = 20'h04000,
        S_SCE    = 20'h08000,
        S_LIN    = 20'h10000,
        S_VEL    = 20'h20000,
        S_ANG    = 20'h40000,
        S_OUT    = 20'h80000
    } t_state;

    t_state r_state, n_state;
    logic   r_kick, n_kick;

    // configuration
    logic [23:0]        r_dpp;
    logic [22:0]        r_wb;
    logic signed [31:0] r_tx;
    logic signed [31:0] r_ty;
    logic [15:0]        r_gl;
    logic [15:0]        r_ga;
    logic [30:0]        r_ar;

    // model state
    logic signed [COUNT_WIDTH-1:0] r_lcnt;
    logic signed [COUNT_WIDTH-1:0] r_rcnt;
    logic signed [31:0]            r_x;
    logic signed [31:0]            r_y;
    logic signed [15:0]            r_h;

    // per-tick working registers
    logic signed [31:0]  r_dl, r_dr, r_d;
    logic signed [15:0]  r_dh, r_h2, r_bear;
    logic signed [31:0]  r_c0, r_s0, r_c1, r_s1, r_cerr;
    logic signed [63:0]  r_prod;
    logic signed [CW-1:0] r_mag;
    logic signed [CW-1:0] r_lin;
    logic signed [16:0]  r_err;
    logic signed [ddo_pkg::SUM_W-1:0] r_v;
    logic signed [8:0]   r_ld, r_rd;
    logic                r_arr;

    // shared units
    logic                             mul_start, mul_done;
    logic signed [MW-1:0]             mul_a, mul_b;
    logic signed [ddo_pkg::PROD_W-1:0] mul_p;
    logic                             div_start, div_done;
    logic signed [ddo_pkg::DIV_NW-1:0] div_n, div_q;
    logic signed [ddo_pkg::DIV_DW-1:0] div_d;
    logic                             cor_start, cor_done, cor_vec;
    logic signed [CW-1:0]             cor_x0, cor_y0, cor_x, cor_y;
    logic signed [ZW-1:0]             cor_z0, cor_z;

    logic                accept;
    logic                same;
    logic signed [17:0]  ang_sel, ang_w, ang_f;
    logic                cor_neg;
    logic signed [32:0]  dx, dy;
    logic                goal_zero;
    logic signed [31:0]  cos_res, sin_res;
    logic signed [ZW-1:0] z_rnd;
    logic signed [15:0]  bear_w;
    logic                arrive;
    logic signed [ddo_pkg::SUM_W-1:0] w_term;

    assign accept = i_item.valid && i_item.ready;
    assign same   = (i_item.enc_a == i_item.enc_b);

    ddo_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p)
    );

    ddo_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_n(div_n), .i_d(div_d), .o_done(div_done), .o_q(div_q)
    );

    ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start), .i_vec(cor_vec),
        .i_x0(cor_x0), .i_y0(cor_y0), .i_z0(cor_z0),
        .o_done(cor_done), .o_x(cor_x), .o_y(cor_y), .o_z(cor_z)
    );

    // multiplier operands
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_start = 1'b0;
        unique case (r_state)
            S_TRAV_L: begin
                mul_a = MW'(r_lcnt);
                mul_b = $signed(MW'(r_dpp));
                mul_start = r_kick;
            end
            S_TRAV_R: begin
                mul_a = MW'(r_rcnt);
                mul_b = $signed(MW'(r_dpp));
                mul_start = r_kick;
            end
            S_MUL_X: begin
                mul_a = MW'(r_d);
                mul_b = MW'(r_c0);
                mul_start = r_kick;
            end
            S_MUL_Y: begin
                mul_a = MW'(r_d);
                mul_b = MW'(r_s0);
                mul_start = r_kick;
            end
            S_MUL_AX: begin
                mul_a = MW'(r_d);
                mul_b = MW'(r_s1) - MW'(r_s0);
                mul_start = r_kick;
            end
            S_MUL_AY: begin
                mul_a = MW'(r_d);
                mul_b = MW'(r_c1) - MW'(r_c0);
                mul_start = r_kick;
            end
            S_MAG: begin
                mul_a = cor_x;
                mul_b = ddo_pkg::KINV_Q24;
                mul_start = r_kick;
            end
            S_LIN: begin
                mul_a = r_mag;
                mul_b = MW'(r_cerr);
                mul_start = r_kick;
            end
            S_VEL: begin
                mul_a = $signed(MW'(r_gl));
                mul_b = r_lin;
                mul_start = r_kick;
            end
            S_ANG: begin
                mul_a = $signed(MW'(r_ga));
                mul_b = MW'(r_err);
                mul_start = r_kick;
            end
            default: ;
        endcase
    end

    // divider operands
    always_comb begin
        div_n     = '0;
        div_d     = '0;
        div_start = 1'b0;
        unique case (r_state)
            S_DIV_DH: begin
                div_n = (64'(r_dr) - 64'(r_dl)) <<< 13;
                div_d = (r_wb == '0) ? 24'sd1 : $signed({1'b0, r_wb});
                div_start = r_kick;
            end
            S_DIV_AX, S_DIV_AY: begin
                div_n = r_prod;
                div_d = 24'(r_dh);
                div_start = r_kick;
            end
            default: ;
        endcase
    end

    // angle fold into +/- pi/2 for rotation mode
    always_comb begin
        unique case (r_state)
            S_SC1:   ang_sel = 18'(r_h2);
            S_SCE:   ang_sel = 18'(r_err);
            default: ang_sel = 18'(r_h);
        endcase
        ang_w = ddo_pkg::wrap_once(ang_sel);
        if (ang_w > ddo_pkg::HALF_PI_Q13) begin
            ang_f   = ang_w - ddo_pkg::PI_Q13;
            cor_neg = 1'b1;
        end else if (ang_w < -ddo_pkg::HALF_PI_Q13) begin
            ang_f   = ang_w + ddo_pkg::PI_Q13;
            cor_neg = 1'b1;
        end else begin
            ang_f   = ang_w;
            cor_neg = 1'b0;
        end
    end

    assign dx        = 33'(r_tx) - 33'(r_x);
    assign dy        = 33'(r_ty) - 33'(r_y);
    assign goal_zero = (dx == '0) && (dy == '0);

    always_comb begin
        cor_vec   = 1'b0;
        cor_x0    = ddo_pkg::KINV_Q30;
        cor_y0    = '0;
        cor_z0    = ZW'(ang_f) <<< 17;
        cor_start = 1'b0;
        unique case (r_state)
            S_SC0, S_SC1, S_SCE: begin
                cor_start = r_kick;
            end
            S_VEC: begin
                cor_vec = 1'b1;
                // left half plane: flip the vector and preload +/- pi
                if (dx[32]) begin
                    cor_x0 = -CW'(dx);
                    cor_y0 = -CW'(dy);
                    cor_z0 = dy[32] ? -ddo_pkg::PI_Q30 : ddo_pkg::PI_Q30;
                end else begin
                    cor_x0 = CW'(dx);
                    cor_y0 = CW'(dy);
                    cor_z0 = '0;
                end
                cor_start = r_kick && !goal_zero;
            end
            default: ;
        endcase
    end

    assign cos_res = cor_neg ? 32'(-cor_x) : 32'(cor_x);
    assign sin_res = cor_neg ? 32'(-cor_y) : 32'(cor_y);
    assign z_rnd   = cor_z + ddo_pkg::BEAR_RND;
    assign bear_w  = 16'(ddo_pkg::wrap_once(18'(z_rnd >>> 17)));
    assign arrive  = (r_mag < $signed(CW'(r_ar)));
    assign w_term  = 56'(mul_p) <<< 7;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept && i_item.command == ddo_pkg::CMD_TICK) n_state = S_TRAV_L;
            S_TRAV_L: if (mul_done) n_state = S_TRAV_R;
            S_TRAV_R: if (mul_done) n_state = S_DIV_DH;
            S_DIV_DH: if (div_done) n_state = S_SC0;
            S_SC0:    if (cor_done) n_state = (r_dh == '0) ? S_MUL_X : S_SC1;
            S_MUL_X:  if (mul_done) n_state = S_MUL_Y;
            S_MUL_Y:  if (mul_done) n_state = S_VEC;
            S_SC1:    if (cor_done) n_state = S_MUL_AX;
            S_MUL_AX: if (mul_done) n_state = S_DIV_AX;
            S_DIV_AX: if (div_done) n_state = S_MUL_AY;
            S_MUL_AY: if (mul_done) n_state = S_DIV_AY;
            S_DIV_AY: if (div_done) n_state = S_VEC;
            S_VEC: begin
                if (r_kick && goal_zero) begin
                    n_state = S_CHK;
                end else if (cor_done) begin
                    n_state = S_MAG;
                end
            end
            S_MAG:    if (mul_done) n_state = S_CHK;
            S_CHK:    n_state = arrive ? S_OUT : S_SCE;
            S_SCE:    if (cor_done) n_state = S_LIN;
            S_LIN:    if (mul_done) n_state = S_VEL;
            S_VEL:    if (mul_done) n_state = S_ANG;
            S_ANG:    if (mul_done) n_state = S_OUT;
            S_OUT:    if (o_result.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        n_kick = (n_state != r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kick  <= 1'b0;
            r_lcnt  <= '0;
            r_rcnt  <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_h     <= '0;
            r_dpp   <= ddo_pkg::DPP_RST;
            r_wb    <= ddo_pkg::WB_RST;
            r_tx    <= '0;
            r_ty    <= '0;
            r_gl    <= ddo_pkg::GL_RST;
            r_ga    <= ddo_pkg::GA_RST;
            r_ar    <= ddo_pkg::RADIUS_RST;
        end else begin
            r_state <= n_state;
            r_kick  <= n_kick;
            if (i_cfg_we) begin
                unique case (ddo_pkg::t_cfg_idx'(i_cfg_idx))
                    ddo_pkg::CFG_DIST:   r_dpp <= i_cfg_data[23:0];
                    ddo_pkg::CFG_WBASE:  r_wb  <= i_cfg_data[22:0];
                    ddo_pkg::CFG_TX:     r_tx  <= $signed(i_cfg_data);
                    ddo_pkg::CFG_TY:     r_ty  <= $signed(i_cfg_data);
                    ddo_pkg::CFG_GLIN:   r_gl  <= i_cfg_data[15:0];
                    ddo_pkg::CFG_GANG:   r_ga  <= i_cfg_data[15:0];
                    ddo_pkg::CFG_RADIUS: r_ar  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_item.command == ddo_pkg::CMD_LEFT) begin
                        if (same) begin
                            if (r_lcnt != CNT_MIN) r_lcnt <= r_lcnt - 1'b1;
                        end else begin
                            if (r_lcnt != CNT_MAX) r_lcnt <= r_lcnt + 1'b1;
                        end
                    end else if (accept && i_item.command == ddo_pkg::CMD_RIGHT) begin
                        if (same) begin
                            if (r_rcnt != CNT_MAX) r_rcnt <= r_rcnt + 1'b1;
                        end else begin
                            if (r_rcnt != CNT_MIN) r_rcnt <= r_rcnt - 1'b1;
                        end
                    end
                end
                S_TRAV_R: begin
                    if (mul_done) begin
                        r_lcnt <= '0;
                        r_rcnt <= '0;
                    end
                end
                S_MUL_X: if (mul_done) r_x <= ddo_pkg::sat32(64'(r_x) + 64'(mul_p >>> 30));
                S_MUL_Y: if (mul_done) r_y <= ddo_pkg::sat32(64'(r_y) + 64'(mul_p >>> 30));
                S_DIV_AX: if (div_done) r_x <= ddo_pkg::sat32(64'(r_x) + (div_q >>> 17));
                S_DIV_AY: begin
                    if (div_done) begin
                        r_y <= ddo_pkg::sat32(64'(r_y) - (div_q >>> 17));
                        r_h <= r_h2;
                    end
                end
                default: ;
            endcase
        end
    end

    // per-tick datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_TRAV_L: if (mul_done) r_dl <= ddo_pkg::travel(mul_p);
            S_TRAV_R: if (mul_done) r_dr <= ddo_pkg::travel(mul_p);
            S_DIV_DH: begin
                if (div_done) begin
                    r_dh <= ddo_pkg::sat_heading(div_q);
                    r_d  <= 32'((33'(r_dl) + 33'(r_dr)) >>> 1);
                end
            end
            S_SC0: begin
                if (cor_done) begin
                    r_c0 <= cos_res;
                    r_s0 <= sin_res;
                    r_h2 <= 16'(ddo_pkg::wrap_once(18'(r_h) + 18'(r_dh)));
                end
            end
            S_SC1: begin
                if (cor_done) begin
                    r_c1 <= cos_res;
                    r_s1 <= sin_res;
                end
            end
            S_MUL_AX, S_MUL_AY: if (mul_done) r_prod <= mul_p[63:0];
            S_VEC: begin
                if (r_kick && goal_zero) begin
                    r_mag  <= '0;
                    r_bear <= '0;
                end
            end
            S_MAG: begin
                if (mul_done) begin
                    r_mag  <= CW'(mul_p >>> 24);
                    r_bear <= bear_w;
                end
            end
            S_CHK: begin
                r_err <= 17'(18'(r_bear) - 18'(r_h));
                r_arr <= arrive;
                if (arrive) begin
                    r_ld <= '0;
                    r_rd <= '0;
                end
            end
            S_SCE: if (cor_done) r_cerr <= cos_res;
            S_LIN: if (mul_done) r_lin <= CW'(mul_p >>> 30);
            S_VEL: if (mul_done) r_v <= 56'(mul_p);
            S_ANG: begin
                if (mul_done) begin
                    r_ld <= ddo_pkg::drive(r_v + w_term);
                    r_rd <= ddo_pkg::drive(r_v - w_term);
                end
            end
            default: ;
        endcase
    end

    assign i_item.ready         = (r_state == S_IDLE);
    assign o_result.valid       = (r_state == S_OUT);
    assign o_result.pos_x       = r_x;
    assign o_result.pos_y       = r_y;
    assign o_result.heading     = r_h;
    assign o_result.left_drive  = r_ld;
    assign o_result.right_drive = r_rd;
    assign o_result.arrived     = r_arr;

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.command == ddo_pkg::CMD_TICK) |=> (r_state == S_TRAV_L))
        else $error("tick transaction did not start the sequence");

    a_counts_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRAV_R && mul_done) |=> (r_lcnt == '0 && r_rcnt == '0))
        else $error("wheel counts not cleared after a tick");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_h <= 16'(ddo_pkg::PI_Q13)) && (r_h >= -16'(ddo_pkg::PI_Q13)))
        else $error("heading left the wrapped range");

    a_arrived_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.arrived) |-> (r_ld == '0 && r_rd == '0))
        else $error("drives not zero on arrival");
endmodule
